FILE: design/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold whenever the block is out of reset
`define SRX_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent in a cycle, consequent in the next
`define SRX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/srx_pkg.sv
// Types and constants of the frame receiver
package srx_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEADER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH    = 2'd3;

  localparam logic [7:0] RST_FIRST_HEADER  = 8'h55;
  localparam logic [7:0] RST_SECOND_HEADER = 8'hAA;
  localparam logic [7:0] RST_DEVICE_ADDR   = 8'h11;
  localparam logic [4:0] RST_MAX_LENGTH    = 5'd30;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_HDR2 = 3'd1;
  localparam logic [2:0] ST_BAD_ADDR = 3'd2;
  localparam logic [2:0] ST_TOO_LONG = 3'd3;
  localparam logic [2:0] ST_BAD_SUM  = 3'd4;
  localparam logic [2:0] ST_TIMEOUT  = 3'd5;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_HDR2 = 3'd1,
    PH_ADDR = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_CSUM = 3'd5
  } srx_phase_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_READ = 2'd1,
    BK_SEND = 2'd2
  } srx_back_state_t;

  typedef struct packed {
    logic       op;
    logic [7:0] byte_value;
  } srx_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] payload_byte;
    logic [4:0] position;
    logic       last;
  } srx_out_t;

  typedef struct packed {
    logic [7:0] first_header;
    logic [7:0] second_header;
    logic [7:0] device_address;
    logic [4:0] max_length;
  } srx_cfg_t;

  typedef struct packed {
    logic       is_frame;
    logic [2:0] status;
    logic [4:0] len;
  } srx_cmd_t;

  typedef struct packed {
    logic       en;
    logic [5:0] idx;
    logic [7:0] data;
  } srx_wr_t;

endpackage

FILE: design/sum_checked_frame_receiver.sv
// Additive-checksum frame receiver: top level with configuration registers
// Input: one transfer per cycle while the two-entry command queue has room;
// data bytes of a new frame wait until the previous frame's payload has drained.
// A status result passes through the command queue and the back end's idle state to
// the output; each payload byte of a good frame is read through the store's registered
// read port, then held in a send state until taken. Reset is synchronous.
module sum_checked_frame_receiver #(
  parameter int PAYLOAD_DEPTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  srx_pkg::srx_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output srx_pkg::srx_out_t                  out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [srx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                         cfg_data
);

  srx_pkg::srx_cfg_t cfg_r, cfg_nxt;
  srx_pkg::srx_cmd_t fq_data, qb_data;
  srx_pkg::srx_wr_t  wr;
  logic fq_valid, fq_ready, qb_valid, qb_ready, frame_done;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        srx_pkg::REG_FIRST_HEADER:  cfg_nxt.first_header   = cfg_data;
        srx_pkg::REG_SECOND_HEADER: cfg_nxt.second_header  = cfg_data;
        srx_pkg::REG_DEVICE_ADDR:   cfg_nxt.device_address = cfg_data;
        srx_pkg::REG_MAX_LENGTH:    cfg_nxt.max_length     = cfg_data[4:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_header   <= srx_pkg::RST_FIRST_HEADER;
      cfg_r.second_header  <= srx_pkg::RST_SECOND_HEADER;
      cfg_r.device_address <= srx_pkg::RST_DEVICE_ADDR;
      cfg_r.max_length     <= srx_pkg::RST_MAX_LENGTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  srx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cmd_valid  (fq_valid),
    .cmd_ready  (fq_ready),
    .cmd_data   (fq_data),
    .wr         (wr),
    .frame_done (frame_done)
  );

  srx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  srx_back #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .cmd_valid  (qb_valid),
    .cmd_ready  (qb_ready),
    .cmd_data   (qb_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .frame_done (frame_done)
  );

endmodule

FILE: design/srx_front.sv
// Front end: header hunt, frame parse, checksum check and payload writes
module srx_front (
  input  logic              clk,
  input  logic              rst_n,
  input  srx_pkg::srx_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  srx_pkg::srx_in_t  in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output srx_pkg::srx_cmd_t cmd_data,
  output srx_pkg::srx_wr_t  wr,
  input  logic              frame_done
);

  srx_pkg::srx_phase_t phase_r, phase_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [4:0] len_r, len_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       pend_r, pend_nxt;
  logic       acc;
  logic [5:0] cnt_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= srx_pkg::PH_HUNT;
      sum_r   <= 8'd0;
      len_r   <= 5'd0;
      cnt_r   <= 6'd0;
      pend_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sum_r   <= sum_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // hold data bytes while the previous frame still drains from the store
  assign in_ready = cmd_ready && !(phase_r == srx_pkg::PH_DATA && pend_r);
  assign acc      = in_valid && in_ready;
  assign cnt_inc  = cnt_r + 6'd1;

  always_comb begin
    phase_nxt   = phase_r;
    sum_nxt     = sum_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    pend_nxt    = pend_r && !frame_done;
    cmd_valid   = 1'b0;
    cmd_data    = '0;
    wr.en       = 1'b0;
    wr.idx      = cnt_r;
    wr.data     = in_data.byte_value;
    if (acc) begin
      if (in_data.op == srx_pkg::OP_TIMEOUT) begin
        cmd_valid       = 1'b1;
        cmd_data.status = srx_pkg::ST_TIMEOUT;
      end else begin
        case (phase_r)
          srx_pkg::PH_HDR2: begin
            if (in_data.byte_value != cfg.second_header) begin
              cmd_valid       = 1'b1;
              cmd_data.status = srx_pkg::ST_BAD_HDR2;
            end else begin
              sum_nxt   = sum_r + in_data.byte_value;
              phase_nxt = srx_pkg::PH_ADDR;
            end
          end
          srx_pkg::PH_ADDR: begin
            if (in_data.byte_value != cfg.device_address) begin
              cmd_valid       = 1'b1;
              cmd_data.status = srx_pkg::ST_BAD_ADDR;
            end else begin
              sum_nxt   = sum_r + in_data.byte_value;
              phase_nxt = srx_pkg::PH_LEN;
            end
          end
          srx_pkg::PH_LEN: begin
            if (in_data.byte_value > {3'd0, cfg.max_length}) begin
              cmd_valid       = 1'b1;
              cmd_data.status = srx_pkg::ST_TOO_LONG;
            end else begin
              sum_nxt   = sum_r + in_data.byte_value;
              len_nxt   = in_data.byte_value[4:0];
              cnt_nxt   = 6'd0;
              phase_nxt = srx_pkg::PH_DATA;
            end
          end
          srx_pkg::PH_DATA: begin
            wr.en   = 1'b1;
            sum_nxt = sum_r + in_data.byte_value;
            cnt_nxt = cnt_inc;
            if (cnt_inc >= {1'b0, len_r} + 6'd1) begin
              phase_nxt = srx_pkg::PH_CSUM;
            end
          end
          srx_pkg::PH_CSUM: begin
            cmd_valid = 1'b1;
            if (in_data.byte_value != sum_r) begin
              cmd_data.status = srx_pkg::ST_BAD_SUM;
            end else begin
              cmd_data.is_frame = 1'b1;
              cmd_data.status   = srx_pkg::ST_OK;
              cmd_data.len      = len_r;
              pend_nxt          = 1'b1;
            end
          end
          default: begin
            if (in_data.byte_value == cfg.first_header) begin
              sum_nxt   = in_data.byte_value;
              cnt_nxt   = 6'd0;
              phase_nxt = srx_pkg::PH_HDR2;
            end else begin
              phase_nxt = srx_pkg::PH_HUNT;
            end
          end
        endcase
      end
      if (cmd_valid) begin
        phase_nxt = srx_pkg::PH_HUNT;
        sum_nxt   = 8'd0;
        cnt_nxt   = 6'd0;
      end
    end
  end

endmodule

FILE: design/srx_queue.sv
// Two-entry queue of commands between front and back end
module srx_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  srx_pkg::srx_cmd_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output srx_pkg::srx_cmd_t pop_data
);

  srx_pkg::srx_cmd_t ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_data   = ent_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: design/srx_back.sv
// Back end: payload store and result sequencer
module srx_back #(
  parameter int PAYLOAD_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  srx_pkg::srx_wr_t  wr,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  srx_pkg::srx_cmd_t cmd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output srx_pkg::srx_out_t out_data,
  output logic              frame_done
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam logic [8:0] DEPTH_W = 9'(PAYLOAD_DEPTH);

  logic [7:0] mem_r [PAYLOAD_DEPTH];
  logic [7:0] rd_data_r;

  srx_pkg::srx_back_state_t state_r, state_nxt;
  logic       frame_r, frame_nxt;
  logic [2:0] stat_r, stat_nxt;
  logic [4:0] pos_r, pos_nxt;
  logic [4:0] len_r, len_nxt;

  logic [8:0] wr_ext, rd_ext;
  logic       rd_in_range;
  logic       is_last;

  assign wr_ext      = {3'd0, wr.idx};
  assign rd_ext      = {4'd0, pos_r};
  assign rd_in_range = rd_ext < DEPTH_W;
  assign is_last     = !frame_r || pos_r == len_r;

  always_ff @(posedge clk) begin
    if (wr.en && wr_ext < DEPTH_W) begin
      mem_r[wr_ext[AW-1:0]] <= wr.data;
    end
    if (state_r == srx_pkg::BK_READ) begin
      rd_data_r <= rd_in_range ? mem_r[rd_ext[AW-1:0]] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srx_pkg::BK_IDLE;
      frame_r <= 1'b0;
      stat_r  <= srx_pkg::ST_OK;
      pos_r   <= 5'd0;
      len_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      frame_r <= frame_nxt;
      stat_r  <= stat_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    frame_nxt  = frame_r;
    stat_nxt   = stat_r;
    pos_nxt    = pos_r;
    len_nxt    = len_r;
    cmd_ready  = 1'b0;
    frame_done = 1'b0;
    case (state_r)
      srx_pkg::BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          frame_nxt = cmd_data.is_frame;
          stat_nxt  = cmd_data.status;
          len_nxt   = cmd_data.len;
          pos_nxt   = 5'd0;
          state_nxt = cmd_data.is_frame ? srx_pkg::BK_READ : srx_pkg::BK_SEND;
        end
      end
      srx_pkg::BK_READ: begin
        state_nxt = srx_pkg::BK_SEND;
      end
      srx_pkg::BK_SEND: begin
        if (out_ready) begin
          if (is_last) begin
            frame_done = frame_r;
            state_nxt  = srx_pkg::BK_IDLE;
          end else begin
            pos_nxt   = pos_r + 5'd1;
            state_nxt = srx_pkg::BK_READ;
          end
        end
      end
      default: begin
        state_nxt = srx_pkg::BK_IDLE;
      end
    endcase
  end

  assign out_valid             = state_r == srx_pkg::BK_SEND;
  assign out_data.status       = stat_r;
  assign out_data.payload_byte = frame_r ? rd_data_r : 8'd0;
  assign out_data.position     = frame_r ? pos_r : 5'd0;
  assign out_data.last         = is_last;

endmodule

FILE: design/srx_checker.sv
// Port-level checker for the frame receiver, bound to the top level
`include "assert_macros.svh"

module srx_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input srx_pkg::srx_out_t out_data
);

  `SRX_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                   out_valid && $stable(out_data),
                   "result dropped or changed while stalled")

  `SRX_ASSERT(a_status_single, clk, rst_n,
              out_valid && out_data.status != srx_pkg::ST_OK |->
                out_data.last && out_data.payload_byte == 8'd0 && out_data.position == 5'd0,
              "status result not a single marked transfer")

  `SRX_ASSERT_NEXT(a_payload_order, clk, rst_n,
                   out_valid && out_ready && out_data.status == srx_pkg::ST_OK && !out_data.last,
                   !out_valid || (out_data.status == srx_pkg::ST_OK &&
                     out_data.position == $past(out_data.position) + 5'd1),
                   "payload transfer out of order")

endmodule

bind sum_checked_frame_receiver srx_checker u_srx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: dv/tb_top.sv
// Testbench for the additive-checksum frame receiver: random framed traffic against a predictor
`timescale 1ns / 100ps

module tb_top;

  localparam int     STORE_DEPTH   = 32;
  localparam int     HOLD_CYCLES   = 400;
  localparam int     SETTLE_CYCLES = 40;
  localparam longint LIMIT_NS      = 6_000_000;

  typedef enum {
    FAULT_NONE,
    FAULT_HDR2,
    FAULT_ADDR,
    FAULT_LEN,
    FAULT_SUM,
    FAULT_TIMEOUT
  } frame_fault_t;

  class frame_scoreboard_t;
    srx_pkg::srx_cfg_t   regs;
    srx_pkg::srx_phase_t phase;
    logic [7:0] sum;
    logic [4:0] len;
    logic [5:0] got;
    logic [7:0] store [STORE_DEPTH];
    srx_pkg::srx_out_t awaited [$];
    int unsigned mismatches;
    int unsigned payload_results;
    int unsigned status_results;

    function new();
      regs.first_header   = srx_pkg::RST_FIRST_HEADER;
      regs.second_header  = srx_pkg::RST_SECOND_HEADER;
      regs.device_address = srx_pkg::RST_DEVICE_ADDR;
      regs.max_length     = srx_pkg::RST_MAX_LENGTH;
      phase = srx_pkg::PH_HUNT;
      sum   = '0;
      len   = '0;
      got   = '0;
      mismatches      = 0;
      payload_results = 0;
      status_results  = 0;
    endfunction

    function void set_reg(logic [srx_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        srx_pkg::REG_FIRST_HEADER:  regs.first_header   = val;
        srx_pkg::REG_SECOND_HEADER: regs.second_header  = val;
        srx_pkg::REG_DEVICE_ADDR:   regs.device_address = val;
        srx_pkg::REG_MAX_LENGTH:    regs.max_length     = val[4:0];
        default: ;
      endcase
    endfunction

    function void raise_status(logic [2:0] st);
      srx_pkg::srx_out_t r;
      r.status       = st;
      r.payload_byte = '0;
      r.position     = '0;
      r.last         = 1'b1;
      awaited.push_back(r);
      phase = srx_pkg::PH_HUNT;
      sum   = '0;
      got   = '0;
    endfunction

    function void note_rx_event(srx_pkg::srx_in_t ev);
      srx_pkg::srx_out_t r;
      logic [7:0] b;
      int         n;
      b = ev.byte_value;
      if (ev.op == srx_pkg::OP_TIMEOUT) begin
        raise_status(srx_pkg::ST_TIMEOUT);
        return;
      end
      case (phase)
        srx_pkg::PH_HDR2: begin
          if (b != regs.second_header) raise_status(srx_pkg::ST_BAD_HDR2);
          else begin
            sum   = sum + b;
            phase = srx_pkg::PH_ADDR;
          end
        end
        srx_pkg::PH_ADDR: begin
          if (b != regs.device_address) raise_status(srx_pkg::ST_BAD_ADDR);
          else begin
            sum   = sum + b;
            phase = srx_pkg::PH_LEN;
          end
        end
        srx_pkg::PH_LEN: begin
          if (b > regs.max_length) raise_status(srx_pkg::ST_TOO_LONG);
          else begin
            sum   = sum + b;
            len   = b[4:0];
            got   = '0;
            phase = srx_pkg::PH_DATA;
          end
        end
        srx_pkg::PH_DATA: begin
          if (int'(got) < STORE_DEPTH) store[got[4:0]] = b;
          sum = sum + b;
          got = got + 6'd1;
          if (int'(got) >= int'(len) + 1) phase = srx_pkg::PH_CSUM;
        end
        srx_pkg::PH_CSUM: begin
          if (b != sum) raise_status(srx_pkg::ST_BAD_SUM);
          else begin
            n = int'(len) + 1;
            for (int i = 0; i < n; i++) begin
              r.status       = srx_pkg::ST_OK;
              r.payload_byte = (i < STORE_DEPTH) ? store[5'(i)] : 8'h00;
              r.position     = 5'(i);
              r.last         = (i + 1 == n);
              awaited.push_back(r);
            end
            phase = srx_pkg::PH_HUNT;
            sum   = '0;
            got   = '0;
          end
        end
        default: begin
          if (b == regs.first_header) begin
            sum   = b;
            got   = '0;
            phase = srx_pkg::PH_HDR2;
          end else begin
            phase = srx_pkg::PH_HUNT;
          end
        end
      endcase
    endfunction

    function string fmt_res(srx_pkg::srx_out_t res);
      return $sformatf("status %0d byte %02h pos %0d last %0b",
                       res.status, res.payload_byte, res.position, res.last);
    endfunction

    function void report(string what, srx_pkg::srx_out_t exp, srx_pkg::srx_out_t act);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: expected %s, got %s", $realtime, what, fmt_res(exp), fmt_res(act));
    endfunction

    function void check_output(srx_pkg::srx_out_t act);
      srx_pkg::srx_out_t exp;
      if (awaited.size() == 0) begin
        exp = '0;
        report("result with nothing awaited", exp, act);
        return;
      end
      exp = awaited.pop_front();
      if (exp.status == srx_pkg::ST_OK) payload_results++;
      else status_results++;
      if (act.status !== exp.status || act.payload_byte !== exp.payload_byte ||
          act.position !== exp.position || act.last !== exp.last)
        report("result mismatch", exp, act);
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  srx_pkg::srx_in_t  in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  srx_pkg::srx_out_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [srx_pkg::CFG_IDX_W-1:0] cfg_index = srx_pkg::REG_FIRST_HEADER;
  logic [7:0] cfg_data  = '0;

  frame_scoreboard_t sb = new();

  bit          hold_request = 1'b0;
  int unsigned holds_done   = 0;
  int unsigned burst_left   = 0;
  int unsigned items_accepted = 0;
  int unsigned noise_items    = 0;
  int unsigned settings_used  = 1;

  sum_checked_frame_receiver #(
    .PAYLOAD_DEPTH(STORE_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_output(out_data);
  end

  initial begin : receiver_side
    int unsigned seg;
    logic [7:0]  mask;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) begin
          @(negedge clk);
          out_ready = 1'b0;
        end
        holds_done++;
      end else if ($urandom_range(0, 3) == 0) begin
        seg = $urandom_range(20, 60);
        for (int k = 0; k < seg; k++) begin
          @(negedge clk);
          out_ready = 1'b1;
        end
      end else begin
        mask = 8'($urandom);
        seg  = $urandom_range(16, 64);
        for (int k = 0; k < seg; k++) begin
          @(negedge clk);
          out_ready = mask[k % 8];
        end
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

  task automatic offer(input srx_pkg::srx_in_t ev);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      for (int k = 0; k < gap; k++) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = ev;
    do @(posedge clk); while (!in_ready);
    sb.note_rx_event(ev);
    items_accepted++;
  endtask

  task automatic offer_byte(input logic [7:0] b);
    srx_pkg::srx_in_t ev;
    ev.op         = srx_pkg::OP_BYTE;
    ev.byte_value = b;
    offer(ev);
  endtask

  task automatic offer_timeout();
    srx_pkg::srx_in_t ev;
    ev.op         = srx_pkg::OP_TIMEOUT;
    ev.byte_value = 8'($urandom);
    offer(ev);
  endtask

  task automatic write_reg(input logic [srx_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_settings(input logic [7:0] fh, input logic [7:0] sh,
                                input logic [7:0] addr, input logic [4:0] max_len);
    write_reg(srx_pkg::REG_FIRST_HEADER, fh);
    write_reg(srx_pkg::REG_SECOND_HEADER, sh);
    write_reg(srx_pkg::REG_DEVICE_ADDR, addr);
    write_reg(srx_pkg::REG_MAX_LENGTH, 8'(max_len));
    settings_used++;
  endtask

  // drop valid, wait for every awaited result, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_frame(input int unsigned len, input frame_fault_t fault);
    logic [7:0]  frame_bytes [$];
    logic [7:0]  sum;
    logic [7:0]  bad;
    int unsigned keep;
    frame_fault_t kind;
    kind = fault;
    if (kind == FAULT_LEN && sb.regs.max_length == 5'd31) kind = FAULT_SUM;
    frame_bytes.push_back(sb.regs.first_header);
    frame_bytes.push_back(sb.regs.second_header);
    frame_bytes.push_back(sb.regs.device_address);
    frame_bytes.push_back(8'(len));
    for (int k = 0; k <= len; k++) frame_bytes.push_back(8'($urandom));
    sum = '0;
    foreach (frame_bytes[k]) sum = sum + frame_bytes[k];
    frame_bytes.push_back(sum);
    keep = frame_bytes.size();
    case (kind)
      FAULT_HDR2: begin
        bad = 8'($urandom);
        if (bad == sb.regs.second_header) bad = ~bad;
        frame_bytes[1] = bad;
        keep = 2;
      end
      FAULT_ADDR: begin
        bad = 8'($urandom);
        if (bad == sb.regs.device_address) bad = ~bad;
        frame_bytes[2] = bad;
        keep = 3;
      end
      FAULT_LEN: begin
        if ($urandom_range(0, 1) == 0) frame_bytes[3] = 8'(sb.regs.max_length) + 8'd1;
        else frame_bytes[3] = 8'($urandom_range(sb.regs.max_length + 1, 255));
        keep = 4;
      end
      FAULT_SUM: frame_bytes[keep - 1] = sum + 8'($urandom_range(1, 255));
      FAULT_TIMEOUT: keep = $urandom_range(1, frame_bytes.size() - 1);
      default: ;
    endcase
    for (int k = 0; k < keep; k++) offer_byte(frame_bytes[k]);
    if (kind == FAULT_TIMEOUT) offer_timeout();
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    int unsigned lim;
    int unsigned len;
    int unsigned n;
    frame_fault_t fault;
    target = items_accepted - noise_items + count;
    while (items_accepted - noise_items < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        lim = sb.regs.max_length;
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, lim)
                                          : $urandom_range(0, (lim < 4) ? lim : 4);
        case ($urandom_range(0, 9))
          6:       fault = FAULT_SUM;
          7:       fault = FAULT_TIMEOUT;
          8:       fault = ($urandom_range(0, 1) == 0) ? FAULT_HDR2 : FAULT_ADDR;
          9:       fault = FAULT_LEN;
          default: fault = FAULT_NONE;
        endcase
        send_frame(len, fault);
      end else if (pick < 17) begin
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
          offer_byte(8'($urandom));
          noise_items++;
        end
      end else begin
        offer_timeout();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: each failure kind, headers as noise, a short good frame
    offer_timeout();
    offer_byte(8'hFF);
    offer_byte(8'h00);
    offer_byte(sb.regs.first_header);
    offer_byte(sb.regs.first_header);
    offer_byte(sb.regs.second_header);
    send_frame(0, FAULT_ADDR);
    offer_byte(sb.regs.first_header);
    offer_byte(sb.regs.second_header);
    offer_byte(sb.regs.device_address);
    offer_byte(8'(sb.regs.max_length) + 8'd1);
    send_frame(0, FAULT_NONE);
    offer_byte(sb.regs.first_header);
    offer_timeout();
    send_frame(0, FAULT_SUM);
    settle();

    apply_settings(8'h00, 8'hFF, 8'h00, 5'd31);
    send_frame(31, FAULT_NONE);
    run_random(15);
    settle();

    apply_settings(8'hFF, 8'h00, 8'hFF, 5'd0);
    send_frame(0, FAULT_NONE);
    offer_byte(sb.regs.first_header);
    offer_byte(sb.regs.second_header);
    offer_byte(sb.regs.device_address);
    offer_byte(8'd1);
    run_random(15);
    settle();

    apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom_range(1, 31)));
    hold_request = 1'b1;
    run_random(70);
    settle();

    $display("Drove %0d input transfers over %0d register settings, %0d long hold-off(s).",
             items_accepted, settings_used, holds_done);
    $display("Checked %0d payload results and %0d status results, %0d mismatch(es).",
             sb.payload_results, sb.status_results, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
